FILE: design/fhc_pkg.sv
// Package for the FSK half-cycle classifier: word types, class codes,
// register map and reset values. Used by every file in the design folder.
`default_nettype none

package fhc_pkg;

  // Width of a half-cycle length and of each window bound.
  localparam int unsigned LENGTH_BITS = 16;

  // Register map: six 32-bit registers at byte address 4*i.
  localparam int unsigned NUM_REGS     = 6;
  localparam int unsigned PADDR_BITS   = $clog2(NUM_REGS * 4);
  localparam int unsigned REG_IDX_BITS = PADDR_BITS - 2;
  localparam int unsigned PDATA_BITS   = 32;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_LONG_MIN  = REG_IDX_BITS'(0),
    REG_LONG_MAX  = REG_IDX_BITS'(1),
    REG_SHORT_MIN = REG_IDX_BITS'(2),
    REG_SHORT_MAX = REG_IDX_BITS'(3),
    REG_MID_MIN   = REG_IDX_BITS'(4),
    REG_MID_MAX   = REG_IDX_BITS'(5)
  } fhc_reg_e;

  typedef enum logic [1:0] {
    CLS_UNDEF = 2'd0,
    CLS_F1    = 2'd1,
    CLS_F2    = 2'd2,
    CLS_F12   = 2'd3
  } fhc_class_e;

  typedef enum logic [1:0] {
    FREQ_UNDEF = 2'd0,
    FREQ_F1    = 2'd1,
    FREQ_F2    = 2'd2
  } fhc_freq_e;

  // Phase in quarter turns.
  localparam logic [1:0] PHASE_0   = 2'd0;
  localparam logic [1:0] PHASE_90  = 2'd1;
  localparam logic [1:0] PHASE_180 = 2'd2;
  localparam logic [1:0] PHASE_270 = 2'd3;

  typedef struct packed {
    logic [LENGTH_BITS-1:0] long_min;
    logic [LENGTH_BITS-1:0] long_max;
    logic [LENGTH_BITS-1:0] short_min;
    logic [LENGTH_BITS-1:0] short_max;
    logic [LENGTH_BITS-1:0] mid_min;
    logic [LENGTH_BITS-1:0] mid_max;
  } fhc_cfg_t;

  localparam fhc_cfg_t CFG_RESET = '{
    long_min:  LENGTH_BITS'(16),
    long_max:  LENGTH_BITS'(20),
    short_min: LENGTH_BITS'(8),
    short_max: LENGTH_BITS'(10),
    mid_min:   LENGTH_BITS'(12),
    mid_max:   LENGTH_BITS'(15)
  };

  typedef struct packed {
    logic [LENGTH_BITS-1:0] length_samples;
    logic                   level_high;
  } fhc_in_t;

  typedef struct packed {
    logic [1:0] raw_class;
    logic [1:0] resolved_freq;
    logic [1:0] phase_quarters;
  } fhc_out_t;

  // What the previous half-cycle left behind.
  typedef struct packed {
    fhc_class_e last_raw;
    fhc_freq_e  last_resolved;
    logic [1:0] phase;
  } fhc_state_t;

endpackage

`default_nettype wire

FILE: design/fhc_classify.sv
// Combinational window classification and phase/frequency update for one
// half-cycle. Depends on fhc_pkg.
`default_nettype none

module fhc_classify (
  input  wire fhc_pkg::fhc_cfg_t   cfg_i,
  input  wire fhc_pkg::fhc_state_t state_i,
  input  wire fhc_pkg::fhc_in_t    word_i,
  output fhc_pkg::fhc_out_t        word_o
);

  logic                  in_long;
  logic                  in_short;
  logic                  in_mid;
  fhc_pkg::fhc_class_e   cls;
  fhc_pkg::fhc_freq_e    res;
  logic [1:0]            phase;

  assign in_long  = (word_i.length_samples >= cfg_i.long_min) &&
                    (word_i.length_samples <= cfg_i.long_max);
  assign in_short = (word_i.length_samples >= cfg_i.short_min) &&
                    (word_i.length_samples <= cfg_i.short_max);
  assign in_mid   = (word_i.length_samples >= cfg_i.mid_min) &&
                    (word_i.length_samples <= cfg_i.mid_max);

  // Windows are checked in priority order, so overlaps go to the first.
  always_comb begin
    if (in_long) begin
      cls = fhc_pkg::CLS_F1;
    end else if (in_short) begin
      cls = fhc_pkg::CLS_F2;
    end else if (in_mid) begin
      cls = fhc_pkg::CLS_F12;
    end else begin
      cls = fhc_pkg::CLS_UNDEF;
    end
  end

  // The phase moves only on a change into a full-length class.
  always_comb begin
    phase = state_i.phase;
    if ((cls != state_i.last_raw) &&
        ((cls == fhc_pkg::CLS_F1) || (cls == fhc_pkg::CLS_F2))) begin
      if ((state_i.last_raw == fhc_pkg::CLS_F1) ||
          (state_i.last_raw == fhc_pkg::CLS_F2)) begin
        phase = word_i.level_high ? fhc_pkg::PHASE_0 : fhc_pkg::PHASE_180;
      end else if (state_i.last_raw == fhc_pkg::CLS_F12) begin
        phase = word_i.level_high ? fhc_pkg::PHASE_270 : fhc_pkg::PHASE_90;
      end
    end
  end

  // A three-quarter half-cycle marks a switch to the other frequency.
  always_comb begin
    case (cls)
      fhc_pkg::CLS_F1: res = fhc_pkg::FREQ_F1;
      fhc_pkg::CLS_F2: res = fhc_pkg::FREQ_F2;
      fhc_pkg::CLS_F12: begin
        case (state_i.last_resolved)
          fhc_pkg::FREQ_F1: res = fhc_pkg::FREQ_F2;
          fhc_pkg::FREQ_F2: res = fhc_pkg::FREQ_F1;
          default:          res = fhc_pkg::FREQ_UNDEF;
        endcase
      end
      default: res = fhc_pkg::FREQ_UNDEF;
    endcase
  end

  assign word_o.raw_class      = cls;
  assign word_o.resolved_freq  = res;
  assign word_o.phase_quarters = phase;

endmodule

`default_nettype wire

FILE: design/fsk_half_cycle_classifier.sv
// Top level of the FSK half-cycle classifier: input register, result
// register, state and APB register file. Depends on fhc_pkg, fhc_classify.
`default_nettype none

// Each input word is one measured half-cycle (length in samples, level).
// The block returns one result word per input word: the raw window class,
// the resolved frequency and the phase estimate after that half-cycle.
// A new word can be accepted in every clock cycle while results are taken;
// an accepted word is held in the input register, and the classification
// and the state update happen as it moves into the result register. That
// step from the input register to the result register, which carries the
// previous class, frequency and phase forward, sets the rate of
// one word per cycle. While a finished result waits to be taken, the input
// register can still take one more word; once it holds that word as well,
// the input stalls until the result is taken. The six window bounds are
// written over the APB port at byte addresses 0, 4, ..., 20; the two low
// address bits are ignored, only the low bits that fit a length are kept,
// and writes past the last register are dropped. Bounds should only be
// changed while no word is in flight. There is no clearing pass: all state
// is ready right after reset.
module fsk_half_cycle_classifier (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Half-cycle input channel
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire fhc_pkg::fhc_in_t                   in_data_i,
  // Result channel
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output fhc_pkg::fhc_out_t                       out_data_o,
  // Configuration port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [fhc_pkg::PADDR_BITS-1:0]     paddr,
  input  wire logic [fhc_pkg::PDATA_BITS-1:0]     pwdata,
  output logic [fhc_pkg::PDATA_BITS-1:0]          prdata,
  output logic                                    pready
);

  fhc_pkg::fhc_cfg_t   cfg_q;
  fhc_pkg::fhc_cfg_t   cfg_d;
  fhc_pkg::fhc_state_t state_q;
  fhc_pkg::fhc_state_t state_d;
  fhc_pkg::fhc_in_t    s1_q;
  fhc_pkg::fhc_out_t   out_q;
  fhc_pkg::fhc_out_t   result;
  logic                s1_valid_q;
  logic                s1_valid_d;
  logic                out_valid_q;
  logic                out_valid_d;
  logic                in_fire;
  logic                out_load;
  logic                cfg_write;
  fhc_pkg::fhc_reg_e   reg_idx;
  logic [fhc_pkg::LENGTH_BITS-1:0] wdata;
  logic [fhc_pkg::LENGTH_BITS-1:0] rdata;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_idx   = fhc_pkg::fhc_reg_e'(paddr[fhc_pkg::PADDR_BITS-1:2]);
  assign wdata     = pwdata[fhc_pkg::LENGTH_BITS-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_write) begin
      case (reg_idx)
        fhc_pkg::REG_LONG_MIN:  cfg_d.long_min  = wdata;
        fhc_pkg::REG_LONG_MAX:  cfg_d.long_max  = wdata;
        fhc_pkg::REG_SHORT_MIN: cfg_d.short_min = wdata;
        fhc_pkg::REG_SHORT_MAX: cfg_d.short_max = wdata;
        fhc_pkg::REG_MID_MIN:   cfg_d.mid_min   = wdata;
        fhc_pkg::REG_MID_MAX:   cfg_d.mid_max   = wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      fhc_pkg::REG_LONG_MIN:  rdata = cfg_q.long_min;
      fhc_pkg::REG_LONG_MAX:  rdata = cfg_q.long_max;
      fhc_pkg::REG_SHORT_MIN: rdata = cfg_q.short_min;
      fhc_pkg::REG_SHORT_MAX: rdata = cfg_q.short_max;
      fhc_pkg::REG_MID_MIN:   rdata = cfg_q.mid_min;
      fhc_pkg::REG_MID_MAX:   rdata = cfg_q.mid_max;
      default:                rdata = '0;
    endcase
  end

  assign prdata = fhc_pkg::PDATA_BITS'(rdata);

  // ---------------------------------------------------------------------
  // Two-register pipeline. A word moves from the input register into the
  // result register when the result register is empty or being emptied;
  // the input register takes a new word whenever it is empty or moving on.
  // ---------------------------------------------------------------------
  assign out_load   = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || out_load;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (out_load) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  fhc_classify u_classify (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .word_i  (s1_q),
    .word_o  (result)
  );

  // The state follows the result of the word just moved to the output.
  always_comb begin
    state_d = state_q;
    if (out_load) begin
      state_d.last_raw      = fhc_pkg::fhc_class_e'(result.raw_class);
      state_d.last_resolved = fhc_pkg::fhc_freq_e'(result.resolved_freq);
      state_d.phase         = result.phase_quarters;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= fhc_pkg::CFG_RESET;
      state_q     <= '{last_raw: fhc_pkg::CLS_UNDEF,
                       last_resolved: fhc_pkg::FREQ_UNDEF,
                       phase: fhc_pkg::PHASE_0};
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      state_q     <= state_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_data_i;
    end
    if (out_load) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------

  // The input side only stalls when both registers are full and the
  // output is held.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a full, held pipeline");

  // After each move to the output, the stored class and phase match that word.
  a_state_tracks_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (state_q.last_raw == out_q.raw_class) &&
                 (state_q.phase == out_q.phase_quarters))
    else $error("state does not follow the last result word");

  // A full-length class resolves to its own frequency.
  a_full_resolves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((out_data_o.raw_class == fhc_pkg::CLS_F1) ||
                     (out_data_o.raw_class == fhc_pkg::CLS_F2)))
    |-> (out_data_o.resolved_freq == out_data_o.raw_class))
    else $error("full-length class resolved to another frequency");

  // Undefined or three-quarter half-cycles never move the phase.
  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && ((result.raw_class == fhc_pkg::CLS_UNDEF) ||
                  (result.raw_class == fhc_pkg::CLS_F12)))
    |=> (state_q.phase == $past(state_q.phase)))
    else $error("phase moved on a half-cycle that must hold it");

  // The resolved frequency never takes the unused code.
  a_freq_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.resolved_freq != 2'd3))
    else $error("resolved frequency out of range");

endmodule

`default_nettype wire

FILE: tb/sv/fhc_result_checker.sv
// Result checker for the FSK half-cycle classifier: watches the APB port and
// both word channels, predicts each result word and compares it.
// Depends on fhc_pkg for the word types, class codes and register map.
module fhc_result_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  input  wire logic                           in_ready_i,
  input  fhc_pkg::fhc_in_t                    in_data_i,
  input  wire logic                           out_valid_i,
  input  wire logic                           out_ready_i,
  input  fhc_pkg::fhc_out_t                   out_data_i,
  input  wire logic                           psel_i,
  input  wire logic                           penable_i,
  input  wire logic                           pwrite_i,
  input  wire logic [fhc_pkg::PADDR_BITS-1:0] paddr_i,
  input  wire logic [fhc_pkg::PDATA_BITS-1:0] pwdata_i,
  input  wire logic                           pready_i,
  output int                                  fail_count_o,
  output int                                  pending_o,
  output int                                  words_checked_o
);

  fhc_pkg::fhc_cfg_t   bounds;
  fhc_pkg::fhc_class_e last_class;
  fhc_pkg::fhc_freq_e  last_freq;
  logic [1:0]          phase;
  fhc_pkg::fhc_out_t   predicted_words[$];
  fhc_pkg::fhc_out_t   want;

  function automatic fhc_pkg::fhc_class_e window_class(
      input logic [fhc_pkg::LENGTH_BITS-1:0] len);
    // Windows are tried in priority order; an empty window never matches.
    if (len >= bounds.long_min && len <= bounds.long_max) return fhc_pkg::CLS_F1;
    if (len >= bounds.short_min && len <= bounds.short_max) return fhc_pkg::CLS_F2;
    if (len >= bounds.mid_min && len <= bounds.mid_max) return fhc_pkg::CLS_F12;
    return fhc_pkg::CLS_UNDEF;
  endfunction

  // Advances the classifier state by one half-cycle and returns its result word.
  function automatic fhc_pkg::fhc_out_t classify_half_cycle(input fhc_pkg::fhc_in_t hc);
    fhc_pkg::fhc_class_e cls;
    fhc_pkg::fhc_freq_e  freq;
    fhc_pkg::fhc_out_t   word;
    cls = window_class(hc.length_samples);
    if (cls != last_class && (cls == fhc_pkg::CLS_F1 || cls == fhc_pkg::CLS_F2)) begin
      if ((last_class == fhc_pkg::CLS_F1 && cls == fhc_pkg::CLS_F2) ||
          (last_class == fhc_pkg::CLS_F2 && cls == fhc_pkg::CLS_F1)) begin
        phase = hc.level_high ? fhc_pkg::PHASE_0 : fhc_pkg::PHASE_180;
      end else if (last_class == fhc_pkg::CLS_F12) begin
        phase = hc.level_high ? fhc_pkg::PHASE_270 : fhc_pkg::PHASE_90;
      end
    end
    case (cls)
      fhc_pkg::CLS_F1:  freq = fhc_pkg::FREQ_F1;
      fhc_pkg::CLS_F2:  freq = fhc_pkg::FREQ_F2;
      fhc_pkg::CLS_F12: begin
        // A three-quarter half-cycle flips the previous resolved frequency.
        if (last_freq == fhc_pkg::FREQ_F1) freq = fhc_pkg::FREQ_F2;
        else if (last_freq == fhc_pkg::FREQ_F2) freq = fhc_pkg::FREQ_F1;
        else freq = fhc_pkg::FREQ_UNDEF;
      end
      default: freq = fhc_pkg::FREQ_UNDEF;
    endcase
    last_class = cls;
    last_freq  = freq;
    word.raw_class      = cls;
    word.resolved_freq  = freq;
    word.phase_quarters = phase;
    return word;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounds          = fhc_pkg::CFG_RESET;
      last_class      = fhc_pkg::CLS_UNDEF;
      last_freq       = fhc_pkg::FREQ_UNDEF;
      phase           = fhc_pkg::PHASE_0;
      predicted_words = {};
      fail_count_o    = 0;
      pending_o       = 0;
      words_checked_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (fhc_pkg::fhc_reg_e'(paddr_i[fhc_pkg::PADDR_BITS-1:2]))
          fhc_pkg::REG_LONG_MIN:  bounds.long_min  = pwdata_i[fhc_pkg::LENGTH_BITS-1:0];
          fhc_pkg::REG_LONG_MAX:  bounds.long_max  = pwdata_i[fhc_pkg::LENGTH_BITS-1:0];
          fhc_pkg::REG_SHORT_MIN: bounds.short_min = pwdata_i[fhc_pkg::LENGTH_BITS-1:0];
          fhc_pkg::REG_SHORT_MAX: bounds.short_max = pwdata_i[fhc_pkg::LENGTH_BITS-1:0];
          fhc_pkg::REG_MID_MIN:   bounds.mid_min   = pwdata_i[fhc_pkg::LENGTH_BITS-1:0];
          fhc_pkg::REG_MID_MAX:   bounds.mid_max   = pwdata_i[fhc_pkg::LENGTH_BITS-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (predicted_words.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("Unexpected result word: class %0d freq %0d phase %0d",
                     out_data_i.raw_class, out_data_i.resolved_freq,
                     out_data_i.phase_quarters);
        end else begin
          want = predicted_words.pop_front();
          if (out_data_i.raw_class !== want.raw_class ||
              out_data_i.resolved_freq !== want.resolved_freq ||
              out_data_i.phase_quarters !== want.phase_quarters) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display({"Mismatch on word %0d: expected class %0d freq %0d phase %0d,",
                        " got class %0d freq %0d phase %0d"},
                       words_checked_o, want.raw_class, want.resolved_freq,
                       want.phase_quarters, out_data_i.raw_class,
                       out_data_i.resolved_freq, out_data_i.phase_quarters);
          end
        end
        words_checked_o++;
      end
      if (in_valid_i && in_ready_i) begin
        predicted_words.push_back(classify_half_cycle(in_data_i));
      end
      pending_o = predicted_words.size();
    end
  end

endmodule

FILE: tb/sv/tb.sv
// Testbench top for the FSK half-cycle classifier: clock, reset, APB writes,
// half-cycle stimulus, output back-pressure and the final verdict.
// Depends on fhc_pkg, fsk_half_cycle_classifier and fhc_result_checker.
module tb;

  // Addresses just past the register map; writes there must be dropped.
  localparam logic [fhc_pkg::PADDR_BITS-1:0] BEYOND_ADDR =
    fhc_pkg::PADDR_BITS'(fhc_pkg::NUM_REGS * 4);

  // Directed half-cycles under the reset windows (F1 16..20, F2 8..10,
  // F12 12..15). They walk the length extremes, every class, every phase
  // transition with both levels, and F12 after undefined, F1 and F2.
  localparam int DIRECTED_COUNT = 16;
  localparam logic [fhc_pkg::LENGTH_BITS-1:0] DIRECTED_LEN [DIRECTED_COUNT] = '{
    0, 65535, 12, 16, 20, 8, 10, 15, 13, 9, 17, 11, 18, 14, 7, 21
  };
  localparam logic DIRECTED_LEVEL [DIRECTED_COUNT] = '{
    0, 1, 1, 1, 0, 0, 1, 0, 1, 0, 1, 0, 1, 1, 0, 1
  };

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  fhc_pkg::fhc_in_t               in_word = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  fhc_pkg::fhc_out_t              out_word;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [fhc_pkg::PADDR_BITS-1:0] paddr = '0;
  logic [fhc_pkg::PDATA_BITS-1:0] pwdata = '0;
  logic [fhc_pkg::PDATA_BITS-1:0] prdata;
  logic                           pready;

  int fail_count;
  int pending;
  int words_checked;

  // Stall shaping: percent of cycles in which each side idles.
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  // Toggling this asks the receiver process for one long hold-off.
  logic hold_toggle = 1'b0;
  logic hold_seen;
  int   hold_left;

  // Stimulus-side copy of the windows, used only to aim lengths at them.
  fhc_pkg::fhc_cfg_t cur_bounds = fhc_pkg::CFG_RESET;
  int                settings_used = 1;

  fsk_half_cycle_classifier DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_word),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  fhc_result_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .in_data_i       (in_word),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .out_data_i      (out_word),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .pready_i        (pready),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .words_checked_o (words_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random back-pressure, or a long hold-off counted here when
  // the stimulus toggles its request.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_seen = 1'b0;
      hold_left = 0;
    end else if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = 300;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // One APB write: a setup phase, an access phase held until pready, and an
  // idle phase so that psel is never dropped and raised in one step.
  task automatic apb_write(input logic [fhc_pkg::PADDR_BITS-1:0] addr,
                           input logic [fhc_pkg::PDATA_BITS-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_windows(input logic [31:0] lmin, input logic [31:0] lmax,
                             input logic [31:0] smin, input logic [31:0] smax,
                             input logic [31:0] mmin, input logic [31:0] mmax);
    apb_write({fhc_pkg::REG_LONG_MIN, 2'b00}, lmin);
    apb_write({fhc_pkg::REG_LONG_MAX, 2'b00}, lmax);
    apb_write({fhc_pkg::REG_SHORT_MIN, 2'b00}, smin);
    apb_write({fhc_pkg::REG_SHORT_MAX, 2'b00}, smax);
    apb_write({fhc_pkg::REG_MID_MIN, 2'b00}, mmin);
    apb_write({fhc_pkg::REG_MID_MAX, 2'b00}, mmax);
    cur_bounds.long_min  = lmin[fhc_pkg::LENGTH_BITS-1:0];
    cur_bounds.long_max  = lmax[fhc_pkg::LENGTH_BITS-1:0];
    cur_bounds.short_min = smin[fhc_pkg::LENGTH_BITS-1:0];
    cur_bounds.short_max = smax[fhc_pkg::LENGTH_BITS-1:0];
    cur_bounds.mid_min   = mmin[fhc_pkg::LENGTH_BITS-1:0];
    cur_bounds.mid_max   = mmax[fhc_pkg::LENGTH_BITS-1:0];
    settings_used++;
  endtask

  // Offers one half-cycle word. Within this task, valid is only lowered during a
  // random idle gap, so back-to-back words keep it high without a second assignment.
  task automatic send_half_cycle(input logic [fhc_pkg::LENGTH_BITS-1:0] len,
                                 input logic lvl);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{length_samples: len, level_high: lvl};
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering words and waits until every predicted result has come
  // back, so the windows can be rewritten while the block is idle.
  task automatic drain_words();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (3) @(posedge clk);
  endtask

  // Mostly plausible tape timing (short, three-quarter and long windows
  // around one base length); now and then six arbitrary bounds, which
  // gives overlapping and empty windows.
  task automatic random_windows();
    int unsigned base;
    int unsigned tol;
    base = $urandom_range(3000, 4);
    tol  = base / 5;
    if ($urandom_range(3) == 0) begin
      set_windows($urandom, $urandom, $urandom_range(65535), $urandom_range(65535),
                  $urandom_range(65535), $urandom_range(65535));
    end else begin
      set_windows(2 * base - tol, 2 * base + tol, base, base + tol,
                  base + base / 2 - tol, base + base / 2 + tol);
    end
  endtask

  // Picks a length aimed at one of the windows, at a window edge, or
  // anywhere in the full range as noise.
  function automatic logic [fhc_pkg::LENGTH_BITS-1:0] pick_length();
    int unsigned sel;
    logic [fhc_pkg::LENGTH_BITS-1:0] lo;
    logic [fhc_pkg::LENGTH_BITS-1:0] hi;
    sel = $urandom_range(9);
    case (sel)
      0, 1, 2: begin lo = cur_bounds.long_min;  hi = cur_bounds.long_max;  end
      3, 4, 5: begin lo = cur_bounds.short_min; hi = cur_bounds.short_max; end
      6, 7:    begin lo = cur_bounds.mid_min;   hi = cur_bounds.mid_max;   end
      8:       return fhc_pkg::LENGTH_BITS'($urandom);
      default: begin
        // Just outside, on or just inside an edge of the long or three-quarter window.
        lo = $urandom_range(1) ? cur_bounds.long_min : cur_bounds.mid_max;
        return lo + fhc_pkg::LENGTH_BITS'($urandom_range(2)) - 1'b1;
      end
    endcase
    if (lo > hi) return fhc_pkg::LENGTH_BITS'($urandom);
    return fhc_pkg::LENGTH_BITS'($urandom_range(hi, lo));
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset windows: extremes, every class and every phase transition.
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      send_half_cycle(DIRECTED_LEN[i], DIRECTED_LEVEL[i]);
    end
    drain_words();

    // Overlapping windows, where the first match in F1, F2, F12 order wins.
    // The long minimum is written with junk in the upper half of the word,
    // and the addresses past the map get writes that must not land.
    set_windows(32'hABCD_000A, 20, 15, 25, 5, 30);
    apb_write(BEYOND_ADDR, 32'h0000_0001);
    apb_write(BEYOND_ADDR + 4, 32'h0000_FFFF);
    send_half_cycle(15, 1'b1);
    send_half_cycle(22, 1'b0);
    send_half_cycle(8, 1'b1);
    send_half_cycle(31, 1'b0);
    drain_words();

    // An empty long window (minimum above maximum) matches nothing.
    set_windows(40, 30, 8, 10, 30, 50);
    send_half_cycle(35, 1'b1);
    send_half_cycle(40, 1'b0);
    send_half_cycle(9, 1'b1);
    drain_words();

    // Bounds at the ends of the length range.
    set_windows(0, 0, 65535, 65535, 0, 65535);
    send_half_cycle(0, 1'b1);
    send_half_cycle(65535, 1'b0);
    send_half_cycle(1, 1'b1);
    drain_words();

    // Random phases: sender light and receiver heavy, then the reverse,
    // then no idling at all with one long receiver hold-off in the middle.
    for (int mode = 0; mode < 3; mode++) begin
      tx_idle_pct <= (mode == 0) ? 10 : (mode == 1) ? 86 : 0;
      rx_idle_pct <= (mode == 0) ? 86 : (mode == 1) ? 10 : 0;
      for (int k = 0; k < 4; k++) begin
        random_windows();
        if (mode == 2 && k == 1) hold_toggle <= ~hold_toggle;
        repeat (42) send_half_cycle(pick_length(), 1'($urandom));
        drain_words();
      end
    end

    repeat (10) @(posedge clk);
    $display("Checked %0d result words across %0d window settings, including", words_checked,
             settings_used);
    $display("overlapping, empty and extreme windows, stalls on both sides and a long hold-off.");
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: the whole run needs well under a tenth of this.
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
